FILE: rtl/core/wbps_pkg.sv
// shared types, constants and register codes for the wildcard byte pattern scanner
package wbps_pkg;

  // default number of window cells
  localparam int unsigned MAX_PATTERN_BYTES_DEF = 16;

  // fixed field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned PAT_IDX_W = 4;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned SPAN_W    = 24;
  localparam int unsigned SEEN_W    = 25;
  localparam int unsigned END_W     = 26;
  localparam int unsigned OFFSET_W  = 26;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [SEEN_W-1:0]   seen_t;
  typedef logic [END_W-1:0]    end_t;
  typedef logic signed [OFFSET_W-1:0] offset_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  // scan direction codes
  typedef enum logic {
    DIR_DOWN = 1'b0,
    DIR_UP   = 1'b1
  } scan_dir_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW       = 3'd0,
    REG_PATTERN_HIGH      = 3'd1,
    REG_WILDCARD_MASK     = 3'd2,
    REG_PATTERN_LENGTH    = 3'd3,
    REG_SCAN_DIRECTION    = 3'd4,
    REG_TARGET_OCCURRENCE = 3'd5,
    REG_SCAN_SPAN         = 3'd6,
    REG_BASE_ADDRESS      = 3'd7
  } cfg_reg_t;

  // live configuration handed from the register file to the datapath
  typedef struct packed {
    logic [63:0]        pattern_low;
    logic [63:0]        pattern_high;
    logic [MASK_W-1:0]  wildcard_mask;
    len_t               pattern_length;
    scan_dir_t          scan_direction;
    count_t             target_occurrence;
    logic [SPAN_W-1:0]  scan_span;
    addr_t              base_address;
  } cfg_t;

  localparam len_t   PATTERN_LENGTH_RST    = 5'd1;
  localparam count_t TARGET_OCCURRENCE_RST = 16'd1;
  localparam count_t COUNT_MAX             = 16'hFFFF;

endpackage

FILE: rtl/core/wbps_if.sv
// valid/ready channel interfaces for the scanner input bytes and results
interface wbps_in_if;
  logic                valid;
  logic                ready;
  wbps_pkg::byte_t     mem_byte;
  logic                first_byte;

  modport source (output valid, output mem_byte, output first_byte, input ready);
  modport sink   (input valid, input mem_byte, input first_byte, output ready);
endinterface

interface wbps_out_if;
  logic                valid;
  logic                ready;
  logic                found;
  wbps_pkg::offset_t   match_offset;
  wbps_pkg::addr_t     match_address;

  modport source (output valid, output found, output match_offset, output match_address,
                  input ready);
  modport sink   (input valid, input found, input match_offset, input match_address,
                  output ready);
endinterface

FILE: rtl/core/wbps_cfg.sv
// configuration register file of the scanner
module wbps_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output wbps_pkg::cfg_t                      cfg
);
  import wbps_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode one register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:       cfg_nxt.pattern_low       = cfg_wdata;
        REG_PATTERN_HIGH:      cfg_nxt.pattern_high      = cfg_wdata;
        REG_WILDCARD_MASK:     cfg_nxt.wildcard_mask     = cfg_wdata[MASK_W-1:0];
        REG_PATTERN_LENGTH:    cfg_nxt.pattern_length    = cfg_wdata[LEN_W-1:0];
        REG_SCAN_DIRECTION:    cfg_nxt.scan_direction    = scan_dir_t'(cfg_wdata[0]);
        REG_TARGET_OCCURRENCE: cfg_nxt.target_occurrence = cfg_wdata[COUNT_W-1:0];
        REG_SCAN_SPAN:         cfg_nxt.scan_span         = cfg_wdata[SPAN_W-1:0];
        REG_BASE_ADDRESS:      cfg_nxt.base_address      = cfg_wdata;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low       <= '0;
      cfg_r.pattern_high      <= '0;
      cfg_r.wildcard_mask     <= '0;
      cfg_r.pattern_length    <= PATTERN_LENGTH_RST;
      cfg_r.scan_direction    <= DIR_DOWN;
      cfg_r.target_occurrence <= TARGET_OCCURRENCE_RST;
      cfg_r.scan_span         <= '0;
      cfg_r.base_address      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/wbps_cell.sv
// one window cell: holds a byte, passes it on, and compares against its pattern byte
module wbps_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  logic             clear,
  input  wbps_pkg::byte_t  byte_in,
  input  wbps_pkg::byte_t  pat_byte,
  input  logic             care,
  output wbps_pkg::byte_t  byte_out,
  output logic             hit
);
  import wbps_pkg::*;

  byte_t win_r;
  byte_t win_nxt;

  // value this cell takes on the current shift
  assign win_nxt = clear ? '0 : byte_in;

  // compare the shifted-in byte, unused or wildcard cells always hit
  assign hit = !care || (win_nxt == pat_byte);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r <= win_nxt;
    end
  end

  assign byte_out = win_r;

endmodule

FILE: rtl/core/wildcard_byte_pattern_scanner_top.sv
// top level of the wildcard byte pattern scanner
//
// in_chan carries one memory byte per word, with first_byte marking the start
// of a scan; out_chan carries one result word per scan: found, the signed
// match offset and base plus offset (zeros when not found). The cfg_ port
// writes one register per cycle; the user must use it only while no scan
// result is pending, as the block does not enforce this. The byte window is
// a row of cells, one per pattern byte, that shift the stream along and
// compare in parallel, so one byte is taken every cycle while in_chan.ready
// is high. A result word passes from the byte that ends the scan through two
// registers before out_chan offers it: one for the match decision and count,
// one for the address add into the output register. in_chan.ready drops
// only when both the decision stage and the output register hold words and
// the receiver stalls; until then bytes keep flowing, one per cycle.
// After reset the registers hold their reset values and the block is idle:
// bytes are ignored until a word with first_byte set arrives.
module wildcard_byte_pattern_scanner_top #(
  parameter int unsigned MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  wbps_in_if.sink                          in_chan,
  wbps_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import wbps_pkg::*;

  cfg_t cfg;

  wbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg
  );

  // handshake and pipeline control
  logic  a_valid_r;
  logic  out_valid_r;
  logic  finished_r;
  logic  b_load;
  logic  in_ready;
  logic  accept;
  logic  active;
  logic  step;

  assign b_load   = !out_valid_r || out_chan.ready;
  assign in_ready = !a_valid_r || b_load;
  assign accept   = in_chan.valid && in_ready;
  assign active   = in_chan.first_byte || !finished_r;
  assign step     = accept && active;

  assign in_chan.ready = in_ready;

  // effective pattern length, clamped to 1..MAX_PATTERN_BYTES
  len_t eff_len;
  logic up;
  logic [127:0] pat_all;

  always_comb begin
    priority if (cfg.pattern_length == '0) begin
      eff_len = len_t'(1);
    end else if (cfg.pattern_length > len_t'(MAX_PATTERN_BYTES)) begin
      eff_len = len_t'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = cfg.pattern_length;
    end
  end

  assign up      = (cfg.scan_direction == DIR_UP);
  assign pat_all = {cfg.pattern_high, cfg.pattern_low};

  // row of window cells, cell 0 holds the newest byte
  byte_t                       win  [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hits;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    len_t                 down_idx;
    logic [PAT_IDX_W-1:0] pidx;
    logic                 in_use;
    byte_t                cell_in;
    logic                 cell_clear;

    // down mode maps the oldest byte in use to pattern byte 0
    assign down_idx = eff_len - len_t'(k) - len_t'(1);
    assign pidx     = up ? PAT_IDX_W'(k) : down_idx[PAT_IDX_W-1:0];
    assign in_use   = len_t'(k) < eff_len;

    if (k == 0) begin : g_head
      assign cell_in    = in_chan.mem_byte;
      assign cell_clear = 1'b0;
    end else begin : g_body
      assign cell_in    = win[k-1];
      assign cell_clear = in_chan.first_byte;
    end

    wbps_cell u_cell (
      .clk      (clk),
      .shift_en (step),
      .clear    (cell_clear),
      .byte_in  (cell_in),
      .pat_byte (pat_all[{pidx, 3'b000} +: BYTE_W]),
      .care     (in_use && !cfg.wildcard_mask[pidx]),
      .byte_out (win[k]),
      .hit      (hits[k])
    );
  end

  // scan counters
  seen_t  bytes_r;
  seen_t  bytes_nxt;
  count_t matches_r;
  count_t matches_base;
  count_t matches_nxt;
  logic   finished_nxt;
  end_t   end_count;
  seen_t  len_ext;
  seen_t  cand;
  logic   cand_ok;
  logic   win_match;
  logic   hit_target;
  logic   ends_here;
  logic   result;
  offset_t cand_off;

  assign len_ext      = {{(SEEN_W-LEN_W){1'b0}}, eff_len};
  assign end_count    = {2'b00, cfg.scan_span} + {{(END_W-LEN_W-1){1'b0}}, eff_len, 1'b0}
                        - end_t'(2);
  assign bytes_nxt    = (in_chan.first_byte ? '0 : bytes_r) + seen_t'(1);
  assign matches_base = in_chan.first_byte ? '0 : matches_r;

  // candidate start is tested only while it lies inside the span
  assign cand_ok   = (bytes_nxt >= len_ext) && ({1'b0, bytes_nxt} <= end_count);
  assign cand      = bytes_nxt - len_ext + seen_t'(1);
  assign win_match = cand_ok && (&hits);

  // saturating match count
  always_comb begin
    matches_nxt = matches_base;
    if (win_match && (matches_base != COUNT_MAX)) begin
      matches_nxt = matches_base + count_t'(1);
    end
  end

  assign hit_target = win_match && (cfg.target_occurrence != '0)
                      && (matches_nxt == cfg.target_occurrence);
  assign ends_here  = {1'b0, bytes_nxt} >= end_count;
  assign result     = hit_target || ends_here;
  assign cand_off   = up ? -offset_t'({1'b0, cand}) : offset_t'({1'b0, cand});

  always_comb begin
    finished_nxt = finished_r;
    if (step) begin
      finished_nxt = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r    <= '0;
      matches_r  <= '0;
      finished_r <= 1'b1;
    end else begin
      finished_r <= finished_nxt;
      if (step) begin
        bytes_r   <= bytes_nxt;
        matches_r <= matches_nxt;
      end
    end
  end

  // decision stage
  logic    a_valid_nxt;
  logic    a_found_r;
  offset_t a_offset_r;

  always_comb begin
    a_valid_nxt = a_valid_r;
    priority if (step && result) begin
      a_valid_nxt = 1'b1;
    end else if (b_load) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result) begin
      a_found_r  <= hit_target;
      a_offset_r <= hit_target ? cand_off : '0;
    end
  end

  // output register with the address add
  logic    out_valid_nxt;
  logic    out_found_r;
  offset_t out_offset_r;
  addr_t   out_addr_r;
  addr_t   addr_nxt;

  assign out_valid_nxt = b_load ? a_valid_r : out_valid_r;
  assign addr_nxt      = a_found_r
                         ? cfg.base_address + {{(ADDR_W-OFFSET_W){a_offset_r[OFFSET_W-1]}},
                                               a_offset_r}
                         : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load && a_valid_r) begin
      out_found_r  <= a_found_r;
      out_offset_r <= a_offset_r;
      out_addr_r   <= addr_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.found         = out_found_r;
  assign out_chan.match_offset  = out_offset_r;
  assign out_chan.match_address = out_addr_r;

endmodule

FILE: rtl/core/wbps_chk.sv
// port-level checks on the scanner result channel, bound to the top level
module wbps_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_found,
  input wbps_pkg::offset_t  out_offset,
  input wbps_pkg::addr_t    out_address
);
  import wbps_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a scan that ends without the target reports zero offset and address
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_offset == '0) && (out_address == '0))
    else $error("not-found result carries a nonzero offset or address");

  // candidate starts begin at one, so a match never sits at offset zero
  a_found_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_offset != '0)
    else $error("match reported at offset zero");

  // reset empties the result path
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word offered right after reset");

endmodule

bind wildcard_byte_pattern_scanner_top wbps_chk u_wbps_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_found   (out_chan.found),
  .out_offset  (out_chan.match_offset),
  .out_address (out_chan.match_address)
);

FILE: dv/wildcard_byte_pattern_scanner_top_tb.sv
// self-checking testbench for the wildcard byte pattern scanner top level
module wildcard_byte_pattern_scanner_top_tb;
  import wbps_pkg::*;

  localparam int unsigned MAX_BYTES      = MAX_PATTERN_BYTES_DEF;
  localparam int          CYCLE_LIMIT    = 600000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          RANDOM_WORDS   = 450;
  localparam int          HOLD_CYCLES    = 150;

  // one expected result word
  typedef struct packed {
    logic        found;
    logic [25:0] off;
    logic [63:0] addr;
  } scan_result_t;

  localparam scan_result_t NOT_FOUND = '0;

  // one row of the directed plan: a register write or an input word
  typedef struct {
    bit           is_reg;
    cfg_reg_t     idx;
    logic [63:0]  val;
    byte_t        b;
    logic         fb;
    bit           typed;
    bit           t_has;
    scan_result_t t_res;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        tx_valid = 1'b0;
  byte_t       tx_byte = '0;
  logic        tx_first = 1'b0;
  logic        rx_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  wbps_in_if  in_chan();
  wbps_out_if out_chan();

  assign in_chan.valid      = tx_valid;
  assign in_chan.mem_byte   = tx_byte;
  assign in_chan.first_byte = tx_first;
  assign out_chan.ready     = rx_ready;

  wildcard_byte_pattern_scanner_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copies used by the scan predictor
  logic [63:0]       sh_pat_lo, sh_pat_hi, sh_base;
  logic [MASK_W-1:0] sh_mask;
  len_t              sh_len;
  scan_dir_t         sh_dir;
  count_t            sh_target;
  logic [SPAN_W-1:0] sh_span;

  // scan state of the predictor
  byte_t       win [MAX_BYTES];
  int unsigned seen;
  count_t      hits;
  bit          scan_done;

  scan_result_t pending_results[$];
  byte_t        feed_q[$];

  int tx_mode, rx_mode;
  int rx_wait;
  int rx_hold_req = 0;
  int mismatches = 0;
  int results_checked = 0;
  int words_sent = 0;
  int cycle_count = 0;
  scan_result_t rx_want;

  initial forever #1 clk = ~clk;

  // cycle counter with run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("[cycle %0d] mismatch on %s: got %0h, expected %0h", cycle_count, what,
               got, want);
  endtask

  // idle cycles before a word: 0 none, 1 occasional, 2 frequent
  function automatic int draw_gap(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic int unsigned eff_len();
    if (sh_len == 0) return 1;
    if (sh_len > MAX_BYTES) return MAX_BYTES;
    return sh_len;
  endfunction

  function automatic byte_t pattern_at(int unsigned j);
    logic [127:0] pat;
    pat = {sh_pat_hi, sh_pat_lo};
    return pat[j*8 +: 8];
  endfunction

  // advance the predicted scan by one byte; returns 1 when a result word is due
  function automatic bit scan_byte(input byte_t b, input logic fb, output scan_result_t r);
    int unsigned len, last_cand, end_cnt, cand, j, k;
    bit up, hit;
    byte_t wb;
    logic [63:0] off64;
    r = NOT_FOUND;
    len = eff_len();
    up = (sh_dir == DIR_UP);
    last_cand = sh_span + len - 1;
    end_cnt = sh_span + 2 * len - 2;
    if (fb) begin
      for (k = 0; k < MAX_BYTES; k++) win[k] = '0;
      seen = 0;
      hits = '0;
      scan_done = 1'b0;
    end
    if (scan_done) return 1'b0;
    for (k = MAX_BYTES - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b;
    seen++;
    if (seen >= len) begin
      cand = seen - len + 1;
      hit = (cand <= last_cand);
      // newest byte faces pattern byte 0 in up mode, the last one in down mode
      for (j = 0; j < len; j++) begin
        wb = up ? win[j] : win[len-1-j];
        if (!sh_mask[j] && wb != pattern_at(j)) hit = 1'b0;
      end
      if (hit) begin
        if (hits != COUNT_MAX) hits++;
        if (sh_target != 0 && hits == sh_target) begin
          off64 = up ? (64'd0 - 64'(cand)) : 64'(cand);
          r.found = 1'b1;
          r.off = off64[25:0];
          r.addr = sh_base + off64;
          scan_done = 1'b1;
          return 1'b1;
        end
      end
    end
    if (seen >= end_cnt) begin
      scan_done = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:       sh_pat_lo = v;
      REG_PATTERN_HIGH:      sh_pat_hi = v;
      REG_WILDCARD_MASK:     sh_mask = v[MASK_W-1:0];
      REG_PATTERN_LENGTH:    sh_len = v[LEN_W-1:0];
      REG_SCAN_DIRECTION:    sh_dir = scan_dir_t'(v[0]);
      REG_TARGET_OCCURRENCE: sh_target = v[COUNT_W-1:0];
      REG_SCAN_SPAN:         sh_span = v[SPAN_W-1:0];
      REG_BASE_ADDRESS:      sh_base = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one word and return at the edge that takes it
  task automatic push_word(byte_t b, logic fb);
    int gap;
    gap = draw_gap(tx_mode);
    if (gap != 0) begin
      tx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tx_valid <= 1'b1;
    tx_byte <= b;
    tx_first <= fb;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // send a word and queue what it should produce; typed rows bring their own answer
  task automatic feed(byte_t b, logic fb, bit typed, bit t_has, scan_result_t t_res);
    scan_result_t r;
    bit has;
    push_word(b, fb);
    has = scan_byte(b, fb, r);
    if (typed) begin
      has = t_has;
      r = t_res;
    end
    if (has) pending_results.push_back(r);
    words_sent++;
  endtask

  // stop sending, wait for every result and let the pipeline empty
  task automatic settle();
    tx_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic plan_row_t reg_row(cfg_reg_t idx, logic [63:0] v);
    plan_row_t row;
    row.is_reg = 1'b1;
    row.idx = idx;
    row.val = v;
    row.b = '0;
    row.fb = 1'b0;
    row.typed = 1'b0;
    row.t_has = 1'b0;
    row.t_res = NOT_FOUND;
    return row;
  endfunction

  function automatic plan_row_t word_row(byte_t b, logic fb, bit typed, bit has,
                                         scan_result_t res);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.idx = REG_PATTERN_LOW;
    row.val = '0;
    row.b = b;
    row.fb = fb;
    row.typed = typed;
    row.t_has = has;
    row.t_res = res;
    return row;
  endfunction

  // result receiver: random stalls, long hold on request, field checks
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_chan.valid && rx_ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result word", {63'd0, out_chan.found}, 64'd0);
        end else begin
          rx_want = pending_results.pop_front();
          if (out_chan.found !== rx_want.found)
            report_mismatch("found", {63'd0, out_chan.found}, {63'd0, rx_want.found});
          if (out_chan.match_offset !== rx_want.off)
            report_mismatch("match_offset", {38'd0, out_chan.match_offset},
                            {38'd0, rx_want.off});
          if (out_chan.match_address !== rx_want.addr)
            report_mismatch("match_address", out_chan.match_address, rx_want.addr);
        end
      end
      if (rx_hold_req != 0) begin
        rx_wait = rx_hold_req;
        rx_hold_req = 0;
      end else if (out_chan.valid && rx_ready) begin
        rx_wait = draw_gap(rx_mode);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      rx_ready <= (rx_wait == 0);
    end
  end

  // stimulus: directed plan, then random setting phases
  initial begin
    plan_row_t    plan[$];
    int           phase, quota, n, r, k, random_words;
    int unsigned  len_e, j;
    bit           hold_armed;
    byte_t        b;
    logic         fb;
    logic [63:0]  v;

    // predictor registers and scan state as after reset
    sh_pat_lo = '0;
    sh_pat_hi = '0;
    sh_mask = '0;
    sh_len = PATTERN_LENGTH_RST;
    sh_dir = DIR_DOWN;
    sh_target = TARGET_OCCURRENCE_RST;
    sh_span = '0;
    sh_base = '0;
    for (k = 0; k < MAX_BYTES; k++) win[k] = '0;
    seen = 0;
    hits = '0;
    scan_done = 1'b1;
    tx_mode = 1;
    rx_mode = 1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle after reset, then a scan with no candidates
    plan.push_back(word_row(8'h55, 1'b0, 1'b1, 1'b0, NOT_FOUND));
    plan.push_back(word_row(8'h00, 1'b1, 1'b1, 1'b1, NOT_FOUND));
    // match at offset 1 from the top address wraps to zero
    plan.push_back(reg_row(REG_SCAN_SPAN, 64'd3));
    plan.push_back(reg_row(REG_BASE_ADDRESS, '1));
    plan.push_back(reg_row(REG_PATTERN_LOW, 64'hA5A5_A5A5_A5A5_A5FF));
    plan.push_back(word_row(8'hFF, 1'b1, 1'b1, 1'b1, '{1'b1, 26'd1, 64'd0}));
    plan.push_back(word_row(8'h00, 1'b0, 1'b1, 1'b0, NOT_FOUND));
    // scan runs out of candidates
    plan.push_back(word_row(8'h00, 1'b1, 1'b0, 1'b0, NOT_FOUND));
    plan.push_back(word_row(8'h01, 1'b0, 1'b0, 1'b0, NOT_FOUND));
    plan.push_back(word_row(8'hFE, 1'b0, 1'b1, 1'b1, NOT_FOUND));
    // zero length acts as one, zero target never matches
    plan.push_back(reg_row(REG_PATTERN_LENGTH, 64'd0));
    plan.push_back(reg_row(REG_TARGET_OCCURRENCE, 64'd0));
    plan.push_back(reg_row(REG_SCAN_SPAN, 64'd1));
    plan.push_back(word_row(8'hFF, 1'b1, 1'b1, 1'b1, NOT_FOUND));
    // oversize length acts as 16, all wildcards in up mode: offset -1
    plan.push_back(reg_row(REG_PATTERN_LENGTH, 64'd31));
    plan.push_back(reg_row(REG_SCAN_DIRECTION, 64'(DIR_UP)));
    plan.push_back(reg_row(REG_WILDCARD_MASK, 64'hFFFF));
    plan.push_back(reg_row(REG_TARGET_OCCURRENCE, 64'd1));
    plan.push_back(reg_row(REG_SCAN_SPAN, 64'd0));
    plan.push_back(reg_row(REG_BASE_ADDRESS, 64'd0));
    plan.push_back(reg_row(REG_PATTERN_HIGH, '1));
    for (k = 0; k < 15; k++)
      plan.push_back(word_row((k % 2) ? 8'hFF : 8'h00, k == 0, 1'b0, 1'b0, NOT_FOUND));
    plan.push_back(word_row(8'hFF, 1'b0, 1'b1, 1'b1, '{1'b1, 26'h3FF_FFFF, '1}));

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        feed(plan[i].b, plan[i].fb, plan[i].typed, plan[i].t_has, plan[i].t_res);
      end
    end

    // random phases, each with fresh settings
    random_words = 0;
    hold_armed = 1'b0;
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      settle();
      v = {$urandom, $urandom};
      write_reg(REG_PATTERN_LOW, (phase == 0) ? '1 : (phase == 1) ? '0 : v);
      v = {$urandom, $urandom};
      write_reg(REG_PATTERN_HIGH, (phase == 0) ? '1 : (phase == 1) ? '0 : v);
      r = $urandom_range(0, 5);
      v = (r == 0) ? 64'd0 : (r == 1) ? 64'hFFFF : 64'($urandom & $urandom & 16'hFFFF);
      write_reg(REG_WILDCARD_MASK, v);
      if ($urandom_range(0, 9) == 0)
        v = $urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(17, 31));
      else
        v = 64'($urandom_range(1, 16));
      if (phase == 0) v = 64'd16;
      if (phase == 1 || phase == 2) v = 64'd1;
      write_reg(REG_PATTERN_LENGTH, v);
      v = (phase == 0) ? 64'(DIR_UP) : 64'($urandom_range(0, 1));
      write_reg(REG_SCAN_DIRECTION, v);
      r = $urandom_range(0, 15);
      v = (r == 0) ? 64'd0 : (r == 1) ? 64'hFFFF : 64'($urandom_range(1, 3));
      if (phase <= 2) v = 64'd1;
      write_reg(REG_TARGET_OCCURRENCE, v);
      v = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 40));
      if (phase == 2) v = 64'd0;
      if (phase == 3) v = 64'hFF_FFFF;
      write_reg(REG_SCAN_SPAN, v);
      r = $urandom_range(0, 5);
      v = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
      write_reg(REG_BASE_ADDRESS, v);

      tx_mode = (phase == 2) ? 0 : $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      quota = $urandom_range(20, 50);
      n = 0;
      while (n < quota) begin
        // refill: planted pattern, pattern bytes out of place, or plain noise
        if (feed_q.size() == 0) begin
          len_e = eff_len();
          r = $urandom_range(0, 9);
          if (r < 5) begin
            for (j = 0; j < len_e; j++) begin
              k = (sh_dir == DIR_UP) ? len_e - 1 - j : j;
              feed_q.push_back(sh_mask[k] ? byte_t'($urandom) : pattern_at(k));
            end
          end else if (r < 8) begin
            repeat ($urandom_range(1, 3))
              feed_q.push_back(pattern_at($urandom_range(0, len_e - 1)));
          end else begin
            repeat ($urandom_range(1, 4)) feed_q.push_back(byte_t'($urandom));
          end
        end
        b = feed_q.pop_front();
        // mostly start a scan when idle, rarely restart one in the middle
        if (scan_done) fb = ($urandom_range(0, 7) != 0);
        else fb = ($urandom_range(0, 39) == 0);
        if (!scan_done || fb) n++;
        // long receiver hold while results keep coming, so the input stalls
        if (phase == 2 && n == 5 && !hold_armed) begin
          rx_hold_req = HOLD_CYCLES;
          hold_armed = 1'b1;
        end
        if ($urandom_range(0, 99) == 0) settle();
        feed(b, fb, 1'b0, 1'b0, NOT_FOUND);
      end
      random_words += n;
      phase++;
    end
    settle();

    $display("run covered %0d input words and %0d checked results in %0d cycles",
             words_sent, results_checked, cycle_count);
    $display("directed cases, %0d random setting phases and a long receiver hold",
             phase);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
